>>> rtl/lld_pkg.sv
// ----------------------------------------------------------------------------
// lld_pkg: shared types and codes of the least loaded dispatcher
// Result status codes, register indexes, configuration and result records.
// ----------------------------------------------------------------------------
package lld_pkg;

	// Size of the server pool; indexes and the register fields are sized for 16
	localparam int MAX_SERVERS = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PENDING_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_DISABLED = 2'd2;

	typedef enum logic [1:0] {
		ST_ADMIT    = 2'd0,
		ST_REFUSE   = 2'd1,
		ST_COMPLETE = 2'd2
	} lld_status_t;

	typedef struct packed {
		logic [4:0]  server_count;
		logic [15:0] pending_limit;
		logic        limit_disabled;
	} lld_cfg_t;

	typedef struct packed {
		lld_status_t status;
		logic [3:0]  chosen_server;
		logic [15:0] pending_now;
	} lld_res_t;

endpackage

>>> rtl/lld_req_if.sv
// ----------------------------------------------------------------------------
// lld_req_if: request channel of the least loaded dispatcher
// Carries one request or completion per transaction.
// ----------------------------------------------------------------------------
interface lld_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [3:0] done_server;

	modport source (output valid, output action, output done_server, input ready);
	modport sink   (input valid, input action, input done_server, output ready);
endinterface

>>> rtl/lld_rsp_if.sv
// ----------------------------------------------------------------------------
// lld_rsp_if: result channel of the least loaded dispatcher
// Carries one result per transaction.
// ----------------------------------------------------------------------------
interface lld_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  chosen_server;
	logic [15:0] pending_now;

	modport source (output valid, output status, output chosen_server, output pending_now,
		input ready);
	modport sink   (input valid, input status, input chosen_server, input pending_now,
		output ready);
endinterface

>>> rtl/lld_ram.sv
// ----------------------------------------------------------------------------
// lld_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lld_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/lld_core.sv
// ----------------------------------------------------------------------------
// lld_core: admission, rotating scan and count update
// Sequencer that reads the in-flight count memory one server a cycle.
// ----------------------------------------------------------------------------
module lld_core #(
	parameter int COUNT_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             action,
	input  logic [3:0]       done_server,
	input  lld_pkg::lld_cfg_t cfg,
	output logic             idle,
	output logic             res_valid,
	output lld_pkg::lld_res_t res,
	input  logic             res_take
);
	import lld_pkg::*;

	localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CW = COUNT_BITS;
	localparam int WW = ((CW > 16) ? CW : 16) + 1;
	localparam int MW = 10;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_CREAD = 4'b0100,
		S_DONE  = 4'b1000
	} lld_state_t;

	lld_state_t    state_q;
	logic [3:0]    sp_q;
	logic [CW-1:0] pend_q;
	logic [4:0]    n_q;
	logic [4:0]    best_q;
	logic [CW-1:0] min_load_q;
	logic          have_q;
	logic          vld_q [MAX_SERVERS];
	lld_res_t      res_q;

	logic [4:0]    rd_idx_s1;
	logic [4:0]    rem_s1;
	logic          rd_vld_s1;
	logic          done_ok_s1;

	logic          we;
	logic [AW-1:0] waddr;
	logic [CW-1:0] wdata;
	logic [AW-1:0] raddr;
	logic [CW-1:0] rdata;

	logic [15:0]   lim;
	logic          refuse;
	logic [4:0]    n_act;
	logic [4:0]    origin;
	logic [4:0]    origin_inc;
	logic [3:0]    sp_next;
	logic          done_ok;
	logic [CW-1:0] load;
	logic          take;
	logic [4:0]    cur_best;
	logic [CW-1:0] cur_load;
	logic          stop;
	logic [4:0]    idx_inc;
	logic [4:0]    next_idx;
	logic [CW-1:0] pend_dec;

	lld_ram #(.WIDTH(CW), .DEPTH(MAX_SERVERS)) u_cnt_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		lim    = (cfg.pending_limit == 16'd0) ? 16'd1 : cfg.pending_limit;
		refuse = (&pend_q) ||
			(!cfg.limit_disabled && ((WW'(pend_q) + WW'(1)) > WW'(lim)));
		if (cfg.server_count == 5'd0) begin
			n_act = 5'd1;
		end else if (MW'(cfg.server_count) > MW'(MAX_SERVERS)) begin
			n_act = 5'(MAX_SERVERS);
		end else begin
			n_act = cfg.server_count;
		end
		origin     = (5'(sp_q) < n_act) ? 5'(sp_q) : 5'd0;
		origin_inc = origin + 5'd1;
		sp_next    = (origin_inc >= n_act) ? 4'd0 : 4'(origin_inc);
		done_ok    = MW'(done_server) < MW'(MAX_SERVERS);
		pend_dec   = (pend_q != '0) ? (pend_q - CW'(1)) : pend_q;

		// Unwritten entries read as zero
		load     = rd_vld_s1 ? rdata : '0;
		take     = !have_q || (load < min_load_q);
		cur_best = take ? rd_idx_s1 : best_q;
		cur_load = take ? load : min_load_q;
		stop     = (take && (load == '0)) || (rem_s1 == 5'd0);
		idx_inc  = rd_idx_s1 + 5'd1;
		next_idx = (idx_inc == n_q) ? 5'd0 : idx_inc;
	end

	// Memory port control
	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					raddr = action ? AW'(done_server) : AW'(origin);
				end
			end
			S_SCAN: begin
				if (stop) begin
					we    = 1'b1;
					waddr = AW'(cur_best);
					wdata = (&cur_load) ? cur_load : (cur_load + CW'(1));
				end else begin
					raddr = AW'(next_idx);
				end
			end
			S_CREAD: begin
				if (done_ok_s1 && (load != '0)) begin
					we    = 1'b1;
					waddr = AW'(rd_idx_s1);
					wdata = load - CW'(1);
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q    <= '0;
			pend_q  <= '0;
			have_q  <= 1'b0;
			for (int i = 0; i < MAX_SERVERS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (action) begin
							pend_q  <= pend_dec;
							state_q <= S_CREAD;
						end else if (refuse) begin
							state_q <= S_DONE;
						end else begin
							sp_q    <= sp_next;
							pend_q  <= pend_q + CW'(1);
							have_q  <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					have_q <= 1'b1;
					if (stop) begin
						state_q <= S_DONE;
					end
				end
				S_CREAD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Scan pipeline and result payload
	always_ff @(posedge clk) begin
		rd_vld_s1 <= vld_q[raddr];
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					res_q.chosen_server <= 4'd0;
					if (action) begin
						rd_idx_s1         <= 5'(done_server);
						done_ok_s1        <= done_ok;
						res_q.status      <= ST_COMPLETE;
						res_q.pending_now <= 16'(pend_dec);
					end else if (refuse) begin
						res_q.status      <= ST_REFUSE;
						res_q.pending_now <= 16'(pend_q);
					end else begin
						n_q               <= n_act;
						rd_idx_s1         <= origin;
						rem_s1            <= n_act - 5'd1;
						res_q.status      <= ST_ADMIT;
						res_q.pending_now <= 16'(pend_q + CW'(1));
					end
				end
			end
			S_SCAN: begin
				best_q     <= cur_best;
				min_load_q <= cur_load;
				if (stop) begin
					res_q.chosen_server <= 4'(cur_best);
				end else begin
					rd_idx_s1 <= next_idx;
					rem_s1    <= rem_s1 - 5'd1;
				end
			end
			S_CREAD: begin
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

>>> rtl/least_loaded_dispatcher.sv
// Scan: a request reads m in-flight counts, m in 1..active servers, and stops early at the
//   first server with none in flight; a completion reads only its own server's count.
// Flow: one transaction at a time; the scan reads the counts one by one through the
//   single read port of the in-flight count memory.
// Reset: arst_n clears the pointer, pending count, entry valid bits and configuration at once;
//   no clearing pass is needed and a request may be accepted in the first cycle after reset.
// ----------------------------------------------------------------------------
// least_loaded_dispatcher: least-connections request dispatcher
// Admits requests against a pending limit that can be disabled, sends each to the
// least loaded server, scanning from a rotating start point, and retires completions.
// ----------------------------------------------------------------------------
module least_loaded_dispatcher #(
	parameter int COUNT_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	lld_req_if.sink                            req,
	lld_rsp_if.source                          rsp,
	input  logic                               cfg_we,
	input  logic [lld_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lld_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import lld_pkg::*;

	lld_cfg_t cfg_q;
	logic     core_idle;
	logic     start;
	logic     res_valid;
	lld_res_t res;
	logic     res_take;
	logic     out_valid_q;
	lld_res_t out_res_q;

	// Configuration registers; writes beyond the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.server_count   <= 5'd1;
			cfg_q.pending_limit  <= 16'd1;
			cfg_q.limit_disabled <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SERVER_COUNT:   cfg_q.server_count   <= cfg_data[4:0];
				REG_PENDING_LIMIT:  cfg_q.pending_limit  <= cfg_data;
				REG_LIMIT_DISABLED: cfg_q.limit_disabled <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Take a new transaction only while the sequencer is idle
	assign req.ready = core_idle;
	assign start     = req.valid && req.ready;

	lld_core #(
		.COUNT_BITS  (COUNT_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (req.action),
		.done_server (req.done_server),
		.cfg         (cfg_q),
		.idle        (core_idle),
		.res_valid   (res_valid),
		.res         (res),
		.res_take    (res_take)
	);

	// Output register: advance a finished result when the slot is free or being
	// emptied, otherwise hold the sequencer in its done state
	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_res_q <= res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_res_q.status;
	assign rsp.chosen_server = out_res_q.chosen_server;
	assign rsp.pending_now   = out_res_q.pending_now;

endmodule

>>> rtl/lld_checker.sv
// ----------------------------------------------------------------------------
// lld_checker: port-level checks of the least loaded dispatcher
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [3:0]  rsp_chosen_server,
	input logic [15:0] rsp_pending_now
);
	import lld_pkg::*;

	// A stalled result holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_chosen_server) && $stable(rsp_pending_now))
		else $error("result changed while stalled");

	// One transaction in flight: ready drops right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second transaction taken while one is in flight");

	// Refusals and completions carry no server
	a_no_server: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_ADMIT) |-> rsp_chosen_server == 4'd0)
		else $error("server reported on a result that is not an admission");

endmodule

bind least_loaded_dispatcher lld_checker u_lld_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_chosen_server (rsp.chosen_server),
	.rsp_pending_now   (rsp.pending_now)
);
